>>> design/pcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths and cell interface structs for the collinear decimator.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int TimeW = 31;
  localparam int ValW  = 32;
  localparam int MagW  = ValW + 1;
  localparam int ProdW = MagW + TimeW;
  localparam int TolW  = 2 * TimeW;

  // Step strobes from the sequencer to every cell
  typedef struct packed {
    logic shift;
    logic mul;
    logic cmp;
  } pcd_ctrl_t;

  // Operands common to all cells for one fit test
  typedef struct packed {
    logic [TimeW-1:0] anchor_time;
    logic [ValW-1:0]  anchor_value;
    logic [TimeW-1:0] dt;
    logic [MagW-1:0]  dvn_mag;
    logic             dvn_neg;
    logic [TolW-1:0]  tol_dt;
  } pcd_ops_t;

endpackage

>>> design/pcd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_cell
// One pending point: holds it, shifts it on to the neighbor, and tests it
// against the line from the anchor to the new sample.
// ----------------------------------------------------------------------------
module pcd_cell import pcd_pkg::*; (
  input  logic             clk_i,
  input  pcd_ctrl_t        ctrl_i,
  input  pcd_ops_t         ops_i,
  input  logic [TimeW-1:0] prev_time_i,
  input  logic [ValW-1:0]  prev_value_i,
  output logic [TimeW-1:0] time_o,
  output logic [ValW-1:0]  value_o,
  output logic             ok_o
);

  logic [TimeW-1:0] time_q;
  logic [ValW-1:0]  value_q;
  logic [TimeW-1:0] di;
  logic [MagW-1:0]  dv;
  logic [MagW-1:0]  dv_mag;
  logic [ProdW-1:0] ma_q, mb_q;
  logic             na_q;
  logic [ProdW:0]   err;
  logic             ok_q;

  // Offsets of this point from the anchor
  assign di     = time_q - ops_i.anchor_time;
  assign dv     = {value_q[ValW-1], value_q} -
                  {ops_i.anchor_value[ValW-1], ops_i.anchor_value};
  assign dv_mag = dv[MagW-1] ? (~dv + MagW'(1)) : dv;

  // Deviation of the cross products
  always_comb begin
    if (na_q != ops_i.dvn_neg) begin
      err = {1'b0, ma_q} + {1'b0, mb_q};
    end else if (ma_q >= mb_q) begin
      err = {1'b0, ma_q - mb_q};
    end else begin
      err = {1'b0, mb_q - ma_q};
    end
  end

  // Shift in from the neighbor, multiply, compare
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      time_q  <= prev_time_i;
      value_q <= prev_value_i;
    end
    if (ctrl_i.mul) begin
      ma_q <= ProdW'(dv_mag * ops_i.dt);
      mb_q <= ProdW'(ops_i.dvn_mag * di);
      na_q <= dv[MagW-1];
    end
    if (ctrl_i.cmp) begin
      ok_q <= err <= (ProdW+1)'(ops_i.tol_dt);
    end
  end

  assign time_o  = time_q;
  assign value_o = value_q;
  assign ok_o    = ok_q;

endmodule

>>> design/polyline_collinear_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_collinear_decimator
// Streaming greedy polyline simplifier over a chain of pending-point cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (op, sample_time, sample_value) enter on in_valid_i when
//   in_stall_o is low. op=0 is a sample, op=1 flushes and ends the record.
//   Result items leave on out_valid_o, held while out_stall_i is high.
//   tolerance is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
//   always high. Write it only while the block is idle.
// Timing:
//   Each item runs through these steps before the next accept: prepare the
//   line, multiply in every cell, compare in every cell, decide. A result
//   is registered in the decide cycle and shows on the following cycle.
//   If a result is still stalled at the decide step, the block waits there.
// Reset:
//   Clears the anchor, the pending count and the output valid flag; tolerance
//   returns to 3277 (0.05 in UQ15.16).
// ----------------------------------------------------------------------------
module polyline_collinear_decimator import pcd_pkg::*; #(
  parameter int PENDING_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [TimeW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [TimeW-1:0] sample_time_i,
  input  logic [ValW-1:0]  sample_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             has_point_o,
  output logic [TimeW-1:0] point_time_o,
  output logic [ValW-1:0]  point_value_o,
  output logic             end_of_record_o
);

  localparam int CntW = $clog2(PENDING_DEPTH + 1);
  localparam logic [TimeW-1:0] TolReset = TimeW'(3277);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_CMP, S_DEC} state_e;

  state_e           state_q;
  logic [TimeW-1:0] tol_q;
  logic             have_anchor_q;
  logic [CntW-1:0]  count_q;
  logic             op_q;
  logic [TimeW-1:0] new_time_q;
  logic [ValW-1:0]  new_value_q;
  logic             out_valid_q, has_point_q, eor_q;
  logic [TimeW-1:0] pt_time_q;
  logic [ValW-1:0]  pt_value_q;
  pcd_ops_t         ops_q;

  pcd_ctrl_t        ctrl;
  logic [TimeW-1:0] cell_time  [PENDING_DEPTH];
  logic [ValW-1:0]  cell_value [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] cell_ok, active;
  logic             all_ok, full, stale, out_free, fit_fail, emit;
  logic [TimeW-1:0] last_time;
  logic [MagW-1:0]  dvn;

  // Cell chain; cell 0 holds the newest pending point
  for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      pcd_cell u_cell (
        .clk_i,
        .ctrl_i      (ctrl),
        .ops_i       (ops_q),
        .prev_time_i (new_time_q),
        .prev_value_i(new_value_q),
        .time_o      (cell_time[i]),
        .value_o     (cell_value[i]),
        .ok_o        (cell_ok[i])
      );
    end else begin : g_body
      pcd_cell u_cell (
        .clk_i,
        .ctrl_i      (ctrl),
        .ops_i       (ops_q),
        .prev_time_i (cell_time[i-1]),
        .prev_value_i(cell_value[i-1]),
        .time_o      (cell_time[i]),
        .value_o     (cell_value[i]),
        .ok_o        (cell_ok[i])
      );
    end
    assign active[i] = CntW'(i) < count_q;
  end

  // Decision terms
  assign all_ok    = &(cell_ok | ~active);
  assign full      = count_q == CntW'(PENDING_DEPTH);
  assign last_time = (count_q != '0) ? cell_time[0] : ops_q.anchor_time;
  assign stale     = new_time_q <= last_time;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fit_fail  = !all_ok;
  assign dvn       = {new_value_q[ValW-1], new_value_q} -
                     {ops_q.anchor_value[ValW-1], ops_q.anchor_value};
  // Decide step produces a result item
  assign emit      = (state_q == S_DEC) && out_free &&
                     (op_q || !have_anchor_q || (!stale && (fit_fail || full)));

  // Step strobes for the cells
  always_comb begin
    ctrl.mul   = state_q == S_MUL;
    ctrl.cmp   = state_q == S_CMP;
    ctrl.shift = (state_q == S_DEC) && out_free && !op_q && have_anchor_q && !stale &&
                 (fit_fail || !full);
  end

  // Sequencer, anchor, store count, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      tol_q              <= TolReset;
      have_anchor_q      <= 1'b0;
      count_q            <= '0;
      out_valid_q        <= 1'b0;
      ops_q.anchor_time  <= '0;
      ops_q.anchor_value <= '0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q        <= op_i;
            new_time_q  <= sample_time_i;
            new_value_q <= sample_value_i;
            state_q     <= S_PREP;
          end
        end
        S_PREP: begin
          ops_q.dt      <= new_time_q - ops_q.anchor_time;
          ops_q.dvn_neg <= dvn[MagW-1];
          ops_q.dvn_mag <= dvn[MagW-1] ? (~dvn + MagW'(1)) : dvn;
          state_q       <= S_MUL;
        end
        S_MUL: begin
          ops_q.tol_dt <= TolW'(tol_q * ops_q.dt);
          state_q      <= S_CMP;
        end
        S_CMP: begin
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (op_q) begin
              // Flush: emit newest pending point, then clear
              has_point_q        <= count_q != '0;
              pt_time_q          <= (count_q != '0) ? cell_time[0] : '0;
              pt_value_q         <= (count_q != '0) ? cell_value[0] : '0;
              eor_q              <= 1'b1;
              have_anchor_q      <= 1'b0;
              count_q            <= '0;
              ops_q.anchor_time  <= '0;
              ops_q.anchor_value <= '0;
            end else if (!have_anchor_q) begin
              // First sample becomes the anchor
              has_point_q        <= 1'b1;
              pt_time_q          <= new_time_q;
              pt_value_q         <= new_value_q;
              eor_q              <= 1'b0;
              have_anchor_q      <= 1'b1;
              count_q            <= '0;
              ops_q.anchor_time  <= new_time_q;
              ops_q.anchor_value <= new_value_q;
            end else if (stale) begin
              // Drop: no result
            end else if (all_ok && !full) begin
              count_q <= count_q + CntW'(1);
            end else if (all_ok) begin
              // Store full: new sample becomes the anchor
              has_point_q        <= 1'b1;
              pt_time_q          <= new_time_q;
              pt_value_q         <= new_value_q;
              eor_q              <= 1'b0;
              count_q            <= '0;
              ops_q.anchor_time  <= new_time_q;
              ops_q.anchor_value <= new_value_q;
            end else begin
              // Fit failed: newest pending point becomes the anchor
              has_point_q        <= 1'b1;
              pt_time_q          <= cell_time[0];
              pt_value_q         <= cell_value[0];
              eor_q              <= 1'b0;
              count_q            <= CntW'(1);
              ops_q.anchor_time  <= cell_time[0];
              ops_q.anchor_value <= cell_value[0];
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign has_point_o     = has_point_q;
  assign point_time_o    = pt_time_q;
  assign point_value_o   = pt_value_q;
  assign end_of_record_o = eor_q;

endmodule

>>> design/pcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks for the collinear decimator, bound to the top level.
// ----------------------------------------------------------------------------
module pcd_checker import pcd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             has_point_o,
  input logic [TimeW-1:0] point_time_o,
  input logic [ValW-1:0]  point_value_o,
  input logic             end_of_record_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only a flush result may come without a point
  a_empty_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_point_o |-> end_of_record_o)
    else $error("empty result outside flush");

  // An empty flush result carries zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_point_o |-> point_time_o == '0 && point_value_o == '0)
    else $error("empty result carries data");

  // One item at a time: stall right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted during work");

endmodule

bind polyline_collinear_decimator pcd_checker u_pcd_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .has_point_o,
  .point_time_o,
  .point_value_o,
  .end_of_record_o
);

>>> tb/polyline_collinear_decimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_collinear_decimator_test
// Drives sample and flush items through the decimator with random idling on
// both sides. An in-bench predictor computes each kept point, and a
// scoreboard compares every result item field by field, oldest first.
// ----------------------------------------------------------------------------

class pcd_scoreboard;
  localparam int Depth = 16;

  typedef struct packed {
    logic        has_point;
    logic [30:0] point_time;
    logic [31:0] point_value;
    logic        end_of_record;
  } kept_point_t;

  kept_point_t      expected_points[$];
  int               error_count;
  int               checked_count;
  int               flush_count;
  int               stale_count;
  bit [30:0]        tolerance;
  bit               anchored;
  bit [30:0]        anchor_t;
  longint           anchor_v;
  bit [30:0]        pend_t[Depth];
  longint           pend_v[Depth];
  int               pend_n;

  function new();
    tolerance = 31'd3277;
    clear_line();
  endfunction

  function void clear_line();
    anchored = 0;
    anchor_t = '0;
    anchor_v = 0;
    pend_n   = 0;
  endfunction

  // Cross-multiplied distance test of one pending point against the line
  function bit within_line(bit [30:0] t, longint v, bit [30:0] tn, longint vn);
    longint unsigned dt, di, ea, eb, err;
    longint da, db;
    dt = longint'(tn - anchor_t);
    di = longint'(t - anchor_t);
    da = v - anchor_v;
    db = vn - anchor_v;
    ea = (da < 0 ? -da : da) * dt;
    eb = (db < 0 ? -db : db) * di;
    if ((da < 0) != (db < 0)) err = ea + eb;
    else err = (ea >= eb) ? ea - eb : eb - ea;
    return err <= longint'(tolerance) * dt;
  endfunction

  function void push_point(bit has, bit [30:0] t, longint v, bit eor);
    kept_point_t p;
    p.has_point     = has;
    p.point_time    = t;
    p.point_value   = v[31:0];
    p.end_of_record = eor;
    expected_points.push_back(p);
  endfunction

  // Note one accepted input item and queue the result it causes
  function void note_input(bit op, bit [30:0] t, bit [31:0] raw);
    longint v;
    bit [30:0] last;
    bit fits;
    v = longint'(signed'(raw));
    if (op) begin
      flush_count++;
      if (pend_n > 0) push_point(1, pend_t[pend_n-1], pend_v[pend_n-1], 1);
      else push_point(0, '0, 0, 1);
      clear_line();
      return;
    end
    if (!anchored) begin
      anchored = 1;
      anchor_t = t;
      anchor_v = v;
      pend_n = 0;
      push_point(1, t, v, 0);
      return;
    end
    last = pend_n ? pend_t[pend_n-1] : anchor_t;
    if (t <= last) begin
      stale_count++;
      return;
    end
    fits = 1;
    for (int i = 0; i < pend_n; i++)
      if (!within_line(pend_t[i], pend_v[i], t, v)) fits = 0;
    if (fits) begin
      if (pend_n < Depth) begin
        pend_t[pend_n] = t;
        pend_v[pend_n] = v;
        pend_n++;
        return;
      end
      anchor_t = t;
      anchor_v = v;
      pend_n = 0;
      push_point(1, t, v, 0);
      return;
    end
    anchor_t = pend_t[pend_n-1];
    anchor_v = pend_v[pend_n-1];
    pend_t[0] = t;
    pend_v[0] = v;
    pend_n = 1;
    push_point(1, anchor_t, anchor_v, 0);
  endfunction

  function void report(string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endfunction

  // Check one accepted result item against the oldest expectation
  function void check_result(bit has, bit [30:0] t, bit [31:0] v, bit eor);
    kept_point_t p;
    checked_count++;
    if (expected_points.size() == 0) begin
      report($sformatf("unexpected result t=%0d v=%h", t, v));
      return;
    end
    p = expected_points.pop_front();
    if (has !== p.has_point)
      report($sformatf("has_point %b, want %b", has, p.has_point));
    if (t !== p.point_time)
      report($sformatf("point_time %0d, want %0d", t, p.point_time));
    if (v !== p.point_value)
      report($sformatf("point_value %h, want %h", v, p.point_value));
    if (eor !== p.end_of_record)
      report($sformatf("end_of_record %b, want %b", eor, p.end_of_record));
  endfunction
endclass

module polyline_collinear_decimator_test;
  import pcd_pkg::*;

  localparam int OpSample = 0;
  localparam int OpFlush  = 1;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [TimeW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             op_i;
  logic [TimeW-1:0] sample_time_i;
  logic [ValW-1:0]  sample_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             has_point_o;
  logic [TimeW-1:0] point_time_o;
  logic [ValW-1:0]  point_value_o;
  logic             end_of_record_o;

  pcd_scoreboard decim_board;
  bit            quiet_phase;
  bit [30:0]     next_time;
  int            item_count;

  polyline_collinear_decimator DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang guard
  initial begin
    #20ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts, check on every accepted item
  initial begin
    int gap;
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        decim_board.check_result(has_point_o, point_time_o, point_value_o,
                                 end_of_record_o);
      if (gap > 0) gap--;
      else if (!quiet_phase && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
      out_stall_i <= (gap > 0);
    end
  end

  // Send one item and wait for its handshake; valid stays up until idling
  task automatic send_item(bit op, bit [30:0] t, bit [31:0] v);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1;
    op_i           <= op;
    sample_time_i  <= t;
    sample_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    decim_board.note_input(op, t, v);
    item_count++;
  endtask

  task automatic send_sample(bit [31:0] v);
    next_time = next_time + 31'($urandom_range(1, 40));
    send_item(OpSample, next_time, v);
  endtask

  task automatic send_flush();
    send_item(OpFlush, 31'($urandom), $urandom);
    next_time = 31'($urandom_range(0, 1000));
  endtask

  // Drain, let the block settle, then write tolerance
  task automatic set_tolerance(bit [30:0] tol);
    in_valid_i <= 0;
    while (decim_board.expected_points.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= tol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    decim_board.tolerance = tol;
    @(posedge clk_i);
  endtask

  // One stroke of a ramp with noise, ending in a flush now and then
  task automatic send_stroke();
    int n, slope, base, noise;
    n = $urandom_range(3, 40);
    base = $urandom;
    slope = $urandom_range(0, 4) == 0 ? $urandom : int'($urandom_range(0, 20000)) - 10000;
    noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        // stale or repeated time
        send_item(OpSample, next_time - 31'($urandom_range(0, 3)), $urandom);
        continue;
      end
      base += slope + int'($urandom_range(0, noise)) - noise / 2;
      send_sample(base);
    end
    if ($urandom_range(0, 2) == 0) send_flush();
  endtask

  initial begin
    decim_board = new();
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    in_valid_i = 0;
    op_i = 0;
    sample_time_i = '0;
    sample_value_i = '0;
    next_time = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty flush, field extremes, stale times, full store
    send_flush();
    send_item(OpSample, 31'd0, 32'h8000_0000);
    send_item(OpSample, 31'd0, 32'h7fff_ffff);
    send_item(OpSample, 31'h7fff_fffe, 32'h7fff_ffff);
    send_item(OpSample, 31'h7fff_ffff, 32'h8000_0000);
    send_flush();
    next_time = 0;
    for (int i = 0; i < 19; i++) send_sample(32'(i * 1000));
    send_flush();
    send_flush();

    set_tolerance(31'd0);
    repeat (12) send_stroke();
    set_tolerance(31'h7fff_ffff);
    repeat (12) send_stroke();
    set_tolerance(31'd3277);
    while (item_count < 900) send_stroke();
    set_tolerance(31'($urandom_range(0, 200000)));
    quiet_phase = 1;
    while (item_count < 1150) send_stroke();
    send_flush();
    in_valid_i <= 0;

    while (decim_board.expected_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d items (%0d flushes, %0d stale samples), checked %0d results",
             item_count, decim_board.flush_count, decim_board.stale_count,
             decim_board.checked_count);
    if (decim_board.error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
design/pcd_pkg.sv
design/pcd_cell.sv
design/polyline_collinear_decimator.sv
design/pcd_checker.sv
tb/polyline_collinear_decimator_test.sv
